>>> hdl/assert_macros.svh
// Assertion macros shared by the allocator modules.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hdl/ffha_pkg.sv
// Types and constants of the first-fit heap allocator.
// No dependencies; used by every module of the block.
package ffha_pkg;

    localparam int ADDR_W = 21;
    localparam int SIZE_W = 22;
    localparam logic [ADDR_W-1:0] HEAP_RESET = 21'd65536;
    localparam logic [SIZE_W-1:0] ALIGN_MASK = 22'd7;
    localparam logic [SIZE_W:0]   MIN_SPLIT  = 23'd8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_INIT,
        OP_LOAD,
        OP_SCAN,
        OP_SET_ERR,
        OP_A_MARK,
        OP_UP_INIT,
        OP_UP_RD,
        OP_UP_WR,
        OP_A_WR_HI,
        OP_A_WR_LO,
        OP_NXT_RD,
        OP_NXT_CAP,
        OP_F_MERGE,
        OP_DN_RD,
        OP_DN_WR,
        OP_F_SHRINK,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic free_req;
        logic null_req;
        logic hit;
        logic exhausted;
        logic split;
        logic up_more;
        logic dn_more;
        logic hit_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        CS_INIT,
        CS_IDLE,
        CS_CHECK,
        CS_SCAN,
        CS_A_DEC,
        CS_A_MV,
        CS_A_MV_WR,
        CS_A_WR_LO,
        CS_F_NXT_RD,
        CS_F_NXT_CAP,
        CS_F_DEC,
        CS_F_MV,
        CS_F_MV_WR,
        CS_FIN
    } ctrl_state_t;

endpackage

>>> hdl/ffha_dp.sv
// Datapath of the allocator: block table memory, scan pipeline, split and merge.
// Depends on ffha_pkg and assert_macros.svh; driven by ffha_ctrl commands.
`include "assert_macros.svh"

module ffha_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffha_pkg::dp_cmd_t   cmd,
    output ffha_pkg::dp_stat_t  stat,
    input  logic                cfg_we,
    input  logic [20:0]         cfg_wdata,
    input  logic                req_type,
    input  logic [20:0]         req_size,
    input  logic [20:0]         req_addr,
    output logic [1:0]          res_status,
    output logic [20:0]         res_addr
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [21:0]   HDR  = 22'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    ffha_pkg::entry_t mem [MAX_BLOCKS];

    logic [20:0]        heap_reg, heap_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic [AW-1:0]      hit_idx_reg, hit_idx_next;
    ffha_pkg::entry_t   hit_reg, hit_next;
    ffha_pkg::entry_t   prev_reg, prev_next;
    ffha_pkg::entry_t   nxt_reg, nxt_next;
    logic               nxt_ok_reg, nxt_ok_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [1:0]         d_reg, d_next;
    logic [21:0]        size_reg, size_next;
    logic [20:0]        addr_reg, addr_next;
    logic               free_reg, free_next;
    ffha_pkg::status_t  res_status_reg, res_status_next;
    logic [20:0]        res_addr_reg, res_addr_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [20:0]        m_addr_reg, m_addr_next;
    ffha_pkg::entry_t   rd_data_reg;

    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    ffha_pkg::entry_t   wr_data;

    logic [CW-1:0]      hit1;
    logic               match, lf, rf;
    logic [20:0]        rem_size, hi_start, lo_addr, merge_size, lsum, rsum;
    logic [AW-1:0]      tgt;
    logic [CW:0]        jd;
    logic [21:0]        rounded;

    always_comb begin
        hit1     = CW'(hit_idx_reg) + CW'(1);
        rounded  = ({1'b0, req_size} + ffha_pkg::ALIGN_MASK) & ~ffha_pkg::ALIGN_MASK;
        if (free_reg) begin
            match = ({1'b0, rd_data_reg.start} + HDR) == {1'b0, addr_reg};
        end else begin
            match = rd_data_reg.free && ({1'b0, rd_data_reg.size} >= size_reg);
        end
        rem_size = hit_reg.size - size_reg[20:0] - HDR[20:0];
        hi_start = hit_reg.start + HDR[20:0] + size_reg[20:0];
        lo_addr  = hit_reg.start + HDR[20:0];
        lf       = (hit_idx_reg != '0) && prev_reg.free;
        rf       = nxt_ok_reg && nxt_reg.free;
        lsum     = lf ? (prev_reg.size + HDR[20:0]) : 21'd0;
        rsum     = rf ? (nxt_reg.size + HDR[20:0]) : 21'd0;
        merge_size = lsum + hit_reg.size + rsum;
        tgt      = lf ? (hit_idx_reg - AW'(1)) : hit_idx_reg;
        jd       = {1'b0, j_reg} + (CW+1)'(d_reg);

        stat.free_req  = free_reg;
        stat.null_req  = free_reg && (addr_reg == '0);
        stat.hit       = pend_reg && match;
        stat.exhausted = !pend_reg && (idx_reg == cnt_reg);
        stat.split     = (cnt_reg < MAXC) &&
                         ({2'b0, hit_reg.size} >= ({1'b0, size_reg} + {1'b0, HDR}
                                                   + ffha_pkg::MIN_SPLIT));
        stat.up_more   = j_reg > hit1;
        stat.dn_more   = (d_reg != 2'd0) && (jd < {1'b0, cnt_reg});
        stat.hit_free  = hit_reg.free;
    end

    always_comb begin
        heap_next       = cfg_we ? cfg_wdata : heap_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        nxt_ok_next     = nxt_ok_reg;
        j_next          = j_reg;
        d_next          = d_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = hit_reg;

        case (cmd.op)
            ffha_pkg::OP_INIT: begin
                wr_en         = 1'b1;
                wr_data.free  = 1'b1;
                wr_data.start = '0;
                wr_data.size  = ({1'b0, heap_reg} >= HDR) ? (heap_reg - HDR[20:0]) : 21'd0;
                cnt_next      = CW'(1);
            end
            ffha_pkg::OP_LOAD: begin
                size_next       = rounded;
                addr_next       = req_addr;
                free_next       = req_type;
                idx_next        = '0;
                pend_next       = 1'b0;
                res_status_next = ffha_pkg::ST_OK;
                res_addr_next   = '0;
            end
            ffha_pkg::OP_SCAN: begin
                // read one entry per cycle, check the one read last cycle
                pend_next = idx_reg < cnt_reg;
                if (idx_reg < cnt_reg) begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                    pidx_next = idx_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if (match) begin
                        hit_idx_next = pidx_reg;
                        hit_next     = rd_data_reg;
                    end else begin
                        prev_next = rd_data_reg;
                    end
                end
            end
            ffha_pkg::OP_SET_ERR: begin
                res_status_next = free_reg ? ffha_pkg::ST_BADADDR : ffha_pkg::ST_OOM;
            end
            ffha_pkg::OP_A_MARK: begin
                wr_en         = 1'b1;
                wr_addr       = hit_idx_reg;
                wr_data.free  = 1'b0;
                res_addr_next = lo_addr;
            end
            ffha_pkg::OP_UP_INIT: begin
                j_next = cnt_reg;
            end
            ffha_pkg::OP_UP_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(j_reg - CW'(1));
            end
            ffha_pkg::OP_UP_WR: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                wr_data = rd_data_reg;
                j_next  = j_reg - CW'(1);
            end
            ffha_pkg::OP_A_WR_HI: begin
                wr_en         = 1'b1;
                wr_addr       = hit1[AW-1:0];
                wr_data.free  = 1'b1;
                wr_data.size  = rem_size;
                wr_data.start = hi_start;
            end
            ffha_pkg::OP_A_WR_LO: begin
                wr_en         = 1'b1;
                wr_addr       = hit_idx_reg;
                wr_data.free  = 1'b0;
                wr_data.size  = size_reg[20:0];
                cnt_next      = cnt_reg + CW'(1);
                res_addr_next = lo_addr;
            end
            ffha_pkg::OP_NXT_RD: begin
                rd_en   = hit1 < cnt_reg;
                rd_addr = hit1[AW-1:0];
            end
            ffha_pkg::OP_NXT_CAP: begin
                nxt_next    = rd_data_reg;
                nxt_ok_next = hit1 < cnt_reg;
            end
            ffha_pkg::OP_F_MERGE: begin
                wr_en         = 1'b1;
                wr_addr       = tgt;
                wr_data.free  = 1'b1;
                wr_data.size  = merge_size;
                wr_data.start = lf ? prev_reg.start : hit_reg.start;
                j_next        = CW'(tgt) + CW'(1);
                d_next        = {1'b0, lf} + {1'b0, rf};
            end
            ffha_pkg::OP_DN_RD: begin
                rd_en   = 1'b1;
                rd_addr = jd[AW-1:0];
            end
            ffha_pkg::OP_DN_WR: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                wr_data = rd_data_reg;
                j_next  = j_reg + CW'(1);
            end
            ffha_pkg::OP_F_SHRINK: begin
                cnt_next = cnt_reg - CW'(d_reg);
            end
            ffha_pkg::OP_LOAD_OUT: begin
                m_status_next = res_status_reg;
                m_addr_next   = res_addr_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_reg <= ffha_pkg::HEAP_RESET;
            cnt_reg  <= CW'(1);
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            j_reg    <= '0;
            d_reg    <= '0;
        end else begin
            heap_reg <= heap_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
            j_reg    <= j_next;
            d_reg    <= d_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg       <= pidx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        nxt_ok_reg     <= nxt_ok_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        free_reg       <= free_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    assign res_status = m_status_reg;
    assign res_addr   = m_addr_reg;

    `FFHA_ASSERT(a_cnt_range, (cnt_reg != '0) && (cnt_reg <= MAXC), "block count out of range")
    `FFHA_ASSERT(a_pend_idx, ((cmd.op == ffha_pkg::OP_SCAN) && pend_reg) |-> (CW'(pidx_reg) < cnt_reg), "scan index beyond count")
    `FFHA_ASSERT(a_up_bound, (cmd.op == ffha_pkg::OP_UP_WR) |-> ((j_reg > hit1) && (j_reg < MAXC)), "shift-up slot invalid")

endmodule

>>> hdl/ffha_ctrl.sv
// Controller of the allocator: sequences scan, split and merge in the datapath.
// Depends on ffha_pkg and assert_macros.svh; owns the handshakes.
`include "assert_macros.svh"

module ffha_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ffha_pkg::dp_cmd_t  cmd,
    input  ffha_pkg::dp_stat_t stat
);

    ffha_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ffha_pkg::CS_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = ffha_pkg::OP_NOP;
        s_tready       = 1'b0;

        case (state_reg)
            ffha_pkg::CS_INIT: begin
                cmd.op     = ffha_pkg::OP_INIT;
                state_next = ffha_pkg::CS_IDLE;
            end
            ffha_pkg::CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = ffha_pkg::OP_LOAD;
                    state_next = ffha_pkg::CS_CHECK;
                end
            end
            ffha_pkg::CS_CHECK: begin
                state_next = stat.null_req ? ffha_pkg::CS_FIN : ffha_pkg::CS_SCAN;
            end
            ffha_pkg::CS_SCAN: begin
                if (stat.hit) begin
                    cmd.op     = ffha_pkg::OP_SCAN;
                    state_next = stat.free_req ? ffha_pkg::CS_F_NXT_RD : ffha_pkg::CS_A_DEC;
                end else if (stat.exhausted) begin
                    cmd.op     = ffha_pkg::OP_SET_ERR;
                    state_next = ffha_pkg::CS_FIN;
                end else begin
                    cmd.op = ffha_pkg::OP_SCAN;
                end
            end
            ffha_pkg::CS_A_DEC: begin
                if (stat.split) begin
                    cmd.op     = ffha_pkg::OP_UP_INIT;
                    state_next = ffha_pkg::CS_A_MV;
                end else begin
                    cmd.op     = ffha_pkg::OP_A_MARK;
                    state_next = ffha_pkg::CS_FIN;
                end
            end
            ffha_pkg::CS_A_MV: begin
                if (stat.up_more) begin
                    cmd.op     = ffha_pkg::OP_UP_RD;
                    state_next = ffha_pkg::CS_A_MV_WR;
                end else begin
                    cmd.op     = ffha_pkg::OP_A_WR_HI;
                    state_next = ffha_pkg::CS_A_WR_LO;
                end
            end
            ffha_pkg::CS_A_MV_WR: begin
                cmd.op     = ffha_pkg::OP_UP_WR;
                state_next = ffha_pkg::CS_A_MV;
            end
            ffha_pkg::CS_A_WR_LO: begin
                cmd.op     = ffha_pkg::OP_A_WR_LO;
                state_next = ffha_pkg::CS_FIN;
            end
            ffha_pkg::CS_F_NXT_RD: begin
                cmd.op     = ffha_pkg::OP_NXT_RD;
                state_next = ffha_pkg::CS_F_NXT_CAP;
            end
            ffha_pkg::CS_F_NXT_CAP: begin
                cmd.op     = ffha_pkg::OP_NXT_CAP;
                state_next = ffha_pkg::CS_F_DEC;
            end
            ffha_pkg::CS_F_DEC: begin
                // freeing a free block changes nothing
                if (stat.hit_free) begin
                    state_next = ffha_pkg::CS_FIN;
                end else begin
                    cmd.op     = ffha_pkg::OP_F_MERGE;
                    state_next = ffha_pkg::CS_F_MV;
                end
            end
            ffha_pkg::CS_F_MV: begin
                if (stat.dn_more) begin
                    cmd.op     = ffha_pkg::OP_DN_RD;
                    state_next = ffha_pkg::CS_F_MV_WR;
                end else begin
                    cmd.op     = ffha_pkg::OP_F_SHRINK;
                    state_next = ffha_pkg::CS_FIN;
                end
            end
            ffha_pkg::CS_F_MV_WR: begin
                cmd.op     = ffha_pkg::OP_DN_WR;
                state_next = ffha_pkg::CS_F_MV;
            end
            ffha_pkg::CS_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = ffha_pkg::OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ffha_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = ffha_pkg::CS_INIT;
            end
        endcase

        // a heap size write rebuilds the table
        if (cfg_we) begin
            state_next = ffha_pkg::CS_INIT;
        end
    end

    assign m_tvalid = out_valid_reg;

    `FFHA_ASSERT_ALWAYS(a_rst_state, !aresetn |=> ((state_reg == ffha_pkg::CS_INIT) && !out_valid_reg), "reset did not restart controller")
    `FFHA_ASSERT(a_out_src, $rose(out_valid_reg) |-> ($past(state_reg) == ffha_pkg::CS_FIN), "result raised outside finish")

endmodule

>>> hdl/first_fit_heap_allocator.sv
// First-fit heap allocator: one result beat per request beat. Each request but a null
// free scans the address-ordered block table one entry per cycle. A split allocate
// moves every table entry above the chosen one up by one slot, and a free that merges
// moves the entries behind the merged block down, each entry read and then written
// through the single read and write port of the table memory.
// After reset or a heap_bytes write the table is rebuilt as one free block.
// Top level; depends on ffha_pkg, ffha_ctrl and ffha_dp.

module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,     // heap_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // [20:0] req_size, [41:21] req_addr, rest zero
    input  logic [0:0]  s_tuser,       // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [20:0] result_addr, rest zero
    output logic [1:0]  m_tuser        // [1:0] status
);

    ffha_pkg::dp_cmd_t  cmd;
    ffha_pkg::dp_stat_t stat;
    logic [20:0]        res_addr;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_type   (s_tuser[0]),
        .req_size   (s_tdata[20:0]),
        .req_addr   (s_tdata[41:21]),
        .res_status (m_tuser),
        .res_addr   (res_addr)
    );

    assign m_tdata = {3'b000, res_addr};

endmodule

>>> bench/tb_first_fit_heap_allocator.sv
// Testbench for first_fit_heap_allocator: directed and random allocate/free requests,
// checked against a block-table model kept in the bench. Needs ffha_pkg and the RTL.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;

    localparam int TBL_DEPTH = 64;
    localparam int HDR = 24;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_OFF_LEN = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [20:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    typedef struct {
        ffha_pkg::status_t st;
        logic [20:0]       addr;
    } alloc_result_t;

    alloc_result_t pending_results[$];

    // heap table as the bench sees it
    logic [20:0] model_heap;
    logic [20:0] tbl_start [TBL_DEPTH];
    logic [20:0] tbl_size  [TBL_DEPTH];
    bit          tbl_free  [TBL_DEPTH];
    int          tbl_count;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_reqs = 0;
    int hold_off_taken = 0;
    int hold_off_cycles = 0;
    int mismatches = 0;
    int cycle_count = 0;

    always #1 aclk = ~aclk;

    first_fit_heap_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic void table_init();
        for (int k = 0; k < TBL_DEPTH; k++) begin
            tbl_start[k] = '0;
            tbl_size[k] = '0;
            tbl_free[k] = 1'b0;
        end
        tbl_size[0] = (model_heap >= HDR) ? 21'(32'(model_heap) - HDR) : '0;
        tbl_free[0] = 1'b1;
        tbl_count = 1;
    endfunction

    function automatic void coalesce();
        int i;
        i = 0;
        while (i + 1 < tbl_count) begin
            if (tbl_free[i] && tbl_free[i+1]) begin
                tbl_size[i] = 21'(32'(tbl_size[i]) + HDR + 32'(tbl_size[i+1]));
                for (int j = i + 1; j + 1 < tbl_count; j++) begin
                    tbl_start[j] = tbl_start[j+1];
                    tbl_size[j] = tbl_size[j+1];
                    tbl_free[j] = tbl_free[j+1];
                end
                tbl_count--;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic alloc_result_t heap_apply(bit is_free, logic [20:0] size,
                                                 logic [20:0] addr);
        alloc_result_t r;
        int unsigned sz;
        int i;
        r.st = ffha_pkg::ST_OK;
        r.addr = '0;
        if (!is_free) begin
            sz = (32'(size) + 7) & ~32'd7;
            for (i = 0; i < tbl_count; i++)
                if (tbl_free[i] && 32'(tbl_size[i]) >= sz) break;
            if (i >= tbl_count) begin
                r.st = ffha_pkg::ST_OOM;
                return r;
            end
            tbl_free[i] = 1'b0;
            if (tbl_count < TBL_DEPTH && 32'(tbl_size[i]) >= sz + HDR + 8) begin
                for (int j = tbl_count; j > i + 1; j--) begin
                    tbl_start[j] = tbl_start[j-1];
                    tbl_size[j] = tbl_size[j-1];
                    tbl_free[j] = tbl_free[j-1];
                end
                tbl_start[i+1] = 21'(32'(tbl_start[i]) + HDR + sz);
                tbl_size[i+1] = 21'(32'(tbl_size[i]) - sz - HDR);
                tbl_free[i+1] = 1'b1;
                tbl_size[i] = 21'(sz);
                tbl_count++;
            end
            r.addr = 21'(32'(tbl_start[i]) + HDR);
        end else if (addr != 0) begin
            for (i = 0; i < tbl_count; i++)
                if (32'(tbl_start[i]) + HDR == 32'(addr)) break;
            if (i >= tbl_count) begin
                r.st = ffha_pkg::ST_BADADDR;
                return r;
            end
            tbl_free[i] = 1'b1;
            coalesce();
        end
        return r;
    endfunction

    // one request beat; s_tvalid stays high after acceptance until the next call
    task automatic send_req(bit is_free, logic [20:0] size, logic [20:0] addr);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_free;
        s_tdata <= {6'b0, addr, size};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(heap_apply(is_free, size, addr));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_heap(logic [20:0] bytes);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= bytes;
        @(posedge aclk);
        cfg_we <= 1'b0;
        model_heap = bytes;
        table_init();
    endtask

    function automatic logic [20:0] pick_block_addr();
        return 21'(32'(tbl_start[$urandom_range(0, tbl_count - 1)]) + HDR);
    endfunction

    task automatic send_random(int max_size);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            send_req(1'b0, (r < 3) ? 21'($urandom) : 21'($urandom_range(0, max_size)),
                     21'($urandom));
        else if (r < 85)
            send_req(1'b1, 21'($urandom), pick_block_addr());
        else if (r < 90)
            send_req(1'b1, 21'($urandom), '0);
        else if (r < 95)
            send_req(1'b1, 21'($urandom), pick_block_addr() + 21'd4);
        else
            send_req(1'b1, 21'($urandom), 21'($urandom));
    endtask

    task automatic test_directed();
        logic [20:0] a0, a1, a2;
        set_heap(21'd65536);
        send_req(1'b0, 21'd0, '0);              // zero size takes first free block
        a0 = pending_results[$].addr;
        send_req(1'b0, 21'd1, 21'h1FFFFF);      // rounds up to 8
        a1 = pending_results[$].addr;
        send_req(1'b0, 21'd100, '0);
        a2 = pending_results[$].addr;
        send_req(1'b0, 21'h1FFFFF, '0);         // out of memory
        send_req(1'b0, 21'd1048576, '0);
        send_req(1'b1, '0, '0);                 // null free
        send_req(1'b1, '0, 21'h1FFFFF);         // unknown address
        send_req(1'b1, '0, a1 + 21'd8);
        send_req(1'b1, 21'h1FFFFF, a1);
        send_req(1'b1, '0, a1);                 // block already free
        send_req(1'b1, '0, a0);                 // merges with neighbor
        send_req(1'b1, '0, a2);
        send_req(1'b0, 21'd65512, '0);          // exactly the whole payload
        send_req(1'b0, 21'd65505, '0);
        set_heap(21'd32);
        send_req(1'b0, 21'd8, '0);
        send_req(1'b0, 21'd0, '0);
        set_heap(21'd16);                       // heap below one header
        send_req(1'b0, 21'd0, '0);
        send_req(1'b0, 21'd1, '0);
        set_heap(21'd1048576);
        send_req(1'b0, 21'd1048552, '0);
        send_req(1'b1, '0, 21'd24);
        // a few small splits in a small heap
        set_heap(21'd2048);
        repeat (5) send_req(1'b0, 21'd8, '0);
    endtask

    task automatic test_random(logic [20:0] heap, int n, int max_size, int s_pct, int r_pct);
        set_heap(heap);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_random(max_size);
    endtask

    task automatic test_backpressure();
        set_heap(21'd4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_reqs++;
        repeat (40) send_random(256);
        wait_drain();
        repeat (10) send_random(256);
    endtask

    task automatic test_table_full();
        set_heap(21'd2048);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (70) send_req(1'b0, 21'($urandom_range(0, 8)), '0);
        repeat (60) send_random(16);
    endtask

    // receiver: random stalls, plus a counted hold-off when requested
    always @(posedge aclk) begin
        if (hold_off_reqs != hold_off_taken) begin
            hold_off_taken <= hold_off_reqs;
            hold_off_cycles <= HOLD_OFF_LEN;
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d addr %0d",
                             m_tuser, m_tdata[20:0]);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.st || m_tdata[20:0] !== want.addr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, addr exp %0d got %0d",
                                 want.st, m_tuser, want.addr, m_tdata[20:0]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_first_fit_heap_allocator: done, errors");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        model_heap = 21'd65536;
        table_init();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(21'd65536, 260, 2048, 35, 87);
        test_random(21'd2048, 200, 64, 87, 35);
        test_random(21'd1048576, 200, 40000, 0, 0);
        test_random(21'd32, 20, 16, 0, 0);
        test_table_full();
        test_backpressure();

        wait_drain();
        repeat (300) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_first_fit_heap_allocator: done, clean");
        else
            $display("tb_first_fit_heap_allocator: done, errors");
        $finish;
    end

endmodule
